// ----- rtl/fps_camera_orientation_update_top_macros.svh -----
// assertion macros for the camera orientation block
`ifndef FPS_CAMERA_ORIENTATION_UPDATE_TOP_MACROS_SVH
`define FPS_CAMERA_ORIENTATION_UPDATE_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define FCO_ASSERT(label, clk_sig, rst_sig, prop, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (prop)) else $error(msg);
`define FCO_ASSERT_NR(label, clk_sig, prop, msg) \
  label: assert property (@(posedge clk_sig) (prop)) else $error(msg);
`else
`define FCO_ASSERT(label, clk_sig, rst_sig, prop, msg)
`define FCO_ASSERT_NR(label, clk_sig, prop, msg)
`endif
`endif

// ----- rtl/fco_pkg.sv -----
// shared types and constants for the camera orientation block
package fco_pkg;
  localparam logic signed [25:0] PITCH_LIM = 26'sd5832704;
  localparam logic signed [25:0] FULL_TURN = 26'sd23592960;
  localparam logic signed [25:0] DEG90 = 26'sd5898240;
  localparam logic signed [25:0] DEG180 = 26'sd11796480;
  localparam logic signed [25:0] DEG270 = 26'sd17694720;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  localparam logic [2:0] REG_ENABLE = 3'd0;
  localparam logic [2:0] REG_UP_AXIS = 3'd1;
  localparam logic [2:0] REG_BASE_SPEED = 3'd2;
  localparam logic [2:0] REG_SENSITIVITY = 3'd3;
  localparam logic [2:0] REG_MAX_DELTA = 3'd4;
  localparam logic [2:0] REG_START_PITCH = 3'd5;
  localparam logic [2:0] REG_START_YAW = 3'd6;

  typedef struct packed {
    logic start;
    logic signed [25:0] angle;
  } cordic_req_t;

  typedef struct packed {
    logic done;
    logic signed [33:0] cos_val;
    logic signed [33:0] sin_val;
  } cordic_rsp_t;

  function automatic logic signed [25:0] atan_deg(input logic [4:0] i);
    case (i)
      5'd0: atan_deg = 26'sd2949120;
      5'd1: atan_deg = 26'sd1740967;
      5'd2: atan_deg = 26'sd919879;
      5'd3: atan_deg = 26'sd466945;
      5'd4: atan_deg = 26'sd234379;
      5'd5: atan_deg = 26'sd117304;
      5'd6: atan_deg = 26'sd58666;
      5'd7: atan_deg = 26'sd29335;
      5'd8: atan_deg = 26'sd14668;
      5'd9: atan_deg = 26'sd7334;
      5'd10: atan_deg = 26'sd3667;
      5'd11: atan_deg = 26'sd1833;
      5'd12: atan_deg = 26'sd917;
      5'd13: atan_deg = 26'sd458;
      5'd14: atan_deg = 26'sd229;
      5'd15: atan_deg = 26'sd115;
      5'd16: atan_deg = 26'sd57;
      5'd17: atan_deg = 26'sd29;
      5'd18: atan_deg = 26'sd14;
      5'd19: atan_deg = 26'sd7;
      5'd20: atan_deg = 26'sd4;
      5'd21: atan_deg = 26'sd2;
      5'd22: atan_deg = 26'sd1;
      default: atan_deg = 26'sd0;
    endcase
  endfunction
endpackage

// ----- rtl/fco_cordic.sv -----
// iterative rotation-mode cordic, one micro-rotation per cycle
`include "fps_camera_orientation_update_top_macros.svh"
module fco_cordic #(
  parameter int STEPS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  fco_pkg::cordic_req_t req,
  output fco_pkg::cordic_rsp_t rsp
);
  localparam int N = (STEPS < 24) ? STEPS : 24;
  logic signed [33:0] x, y;
  logic signed [25:0] z;
  logic [4:0] i;
  logic busy;
  logic done_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy && !req.start && (i == 5'(N - 1));
      if (req.start) begin
        busy <= 1'b1;
        i <= '0;
        x <= fco_pkg::CORDIC_GAIN;
        y <= '0;
        z <= req.angle;
      end else if (busy) begin
        if (!z[25]) begin
          x <= x - (y >>> i);
          y <= y + (x >>> i);
          z <= z - fco_pkg::atan_deg(i);
        end else begin
          x <= x + (y >>> i);
          y <= y - (x >>> i);
          z <= z + fco_pkg::atan_deg(i);
        end
        i <= i + 5'd1;
        if (i == 5'(N - 1)) busy <= 1'b0;
      end
    end
  end
  assign rsp = {done_r, x, y};

  `FCO_ASSERT(a_no_restart, clk, rst, busy |-> !req.start, "cordic restarted while busy")
  `FCO_ASSERT(a_done_ends, clk, rst, rsp.done |-> !busy, "done while still busy")
  `FCO_ASSERT(a_step_range, clk, rst, busy |-> (i < 5'(N)), "step count overrun")
endmodule

// ----- rtl/fps_camera_orientation_update_top.sv -----
// top level of the first-person camera orientation and motion block
// A moving frame tick runs every step below from one acceptance to the next; a tick
// without movement skips the travel length and the position steps, and a place or
// disabled tick also skips the angle products and the yaw wrap. The time goes to two
// angle products and a four-step yaw wrap, two cordic passes of one micro-rotation per
// cycle, then four vector products, the travel length and three position steps through
// one shared 34x34 multiplier with a registered result; ready is low from acceptance
// until the result is taken.
`include "fps_camera_orientation_update_top_macros.svh"
module fps_camera_orientation_update_top #(
  parameter int CORDIC_STEPS = 16,
  parameter int VECTOR_FRAC_BITS = 14,
  parameter int POSITION_FRAC_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic op,
  input  logic key_forward,
  input  logic key_back,
  input  logic key_rightward,
  input  logic key_leftward,
  input  logic signed [15:0] cursor_x,
  input  logic signed [15:0] cursor_y,
  input  logic [15:0] time_step,
  input  logic signed [31:0] place_x,
  input  logic signed [31:0] place_y,
  input  logic signed [31:0] place_z,
  output logic out_valid,
  input  logic out_ready,
  output logic signed [15:0] front_x,
  output logic signed [15:0] front_y,
  output logic signed [15:0] front_z,
  output logic signed [15:0] right_x,
  output logic signed [15:0] right_y,
  output logic signed [15:0] right_z,
  output logic signed [15:0] up_x,
  output logic signed [15:0] up_y,
  output logic signed [15:0] up_z,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic signed [31:0] pos_z,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [31:0] cfg_data
);
  localparam int VSH = 30 - VECTOR_FRAC_BITS;
  localparam int MSH = 24 + VECTOR_FRAC_BITS - POSITION_FRAC_BITS;
  localparam logic signed [33:0] VONE = 34'sd1 <<< VECTOR_FRAC_BITS;

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001, S_ANG = 10'b0000000010, S_CP = 10'b0000000100,
    S_WP = 10'b0000001000, S_CY = 10'b0000010000, S_WY = 10'b0000100000,
    S_MUL = 10'b0001000000, S_MOVE = 10'b0010000000, S_OUT = 10'b0100000000,
    S_WRAP = 10'b1000000000
  } state_t;
  state_t state;

  logic enable;
  logic [1:0] up_axis;
  logic [15:0] base_speed, sensitivity;
  logic [11:0] max_delta;
  logic [23:0] start_pitch;
  logic [24:0] start_yaw;

  logic signed [25:0] pitch, yaw;
  logic signed [15:0] last_x, last_y;
  logic signed [31:0] pos [3];

  logic r_kf, r_kb, r_kr, r_kl, tick, flip;
  logic signed [16:0] r_dx, r_dy;
  logic [15:0] r_dt;
  logic signed [33:0] cp, sp, cyw, syw;
  logic signed [33:0] fa, fu, fb, ra, rb, ua, uu, ub;
  logic [3:0] mi;
  logic mph;
  logic signed [67:0] prod;
  logic signed [33:0] ma, mb;
  logic signed [33:0] travel;
  logic signed [29:0] ywork;
  logic [2:0] wk;

  fco_pkg::cordic_req_t creq;
  fco_pkg::cordic_rsp_t crsp;
  fco_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (.clk, .rst, .req(creq), .rsp(crsp));

  function automatic logic signed [33:0] to_vec(input logic signed [33:0] v);
    logic signed [33:0] r;
    r = (v + (34'sd1 <<< (VSH - 1))) >>> VSH;
    if (r > VONE) r = VONE;
    if (r < -VONE) r = -VONE;
    to_vec = r;
  endfunction

  function automatic logic signed [33:0] rnd30(input logic signed [67:0] p);
    logic signed [67:0] t;
    t = (p + (68'sd1 <<< 29)) >>> 30;
    rnd30 = t[33:0];
  endfunction

  function automatic logic signed [16:0] clampd(input logic signed [16:0] d,
                                                 input logic [11:0] lim);
    logic signed [16:0] l;
    l = {5'd0, lim};
    if (d > l) clampd = l;
    else if (d < -l) clampd = -l;
    else clampd = d;
  endfunction

  // product operand selection
  always_comb begin
    ma = cyw; mb = cp;
    case (mi)
      4'd0: begin ma = {{17{r_dy[16]}}, r_dy}; mb = {18'd0, sensitivity}; end
      4'd1: begin ma = {{17{r_dx[16]}}, r_dx}; mb = {18'd0, sensitivity}; end
      4'd2: begin ma = cyw; mb = cp; end
      4'd3: begin ma = syw; mb = cp; end
      4'd4: begin ma = cyw; mb = sp; end
      4'd5: begin ma = syw; mb = sp; end
      4'd6: begin ma = {18'd0, base_speed}; mb = {18'd0, r_dt}; end
      4'd7, 4'd8, 4'd9: begin
        ma = travel;
        case (mi)
          4'd7: mb = (r_kf || r_kb) ? fa : ra;
          4'd8: mb = (r_kf || r_kb) ? fu : 34'sd0;
          default: mb = (r_kf || r_kb) ? fb : rb;
        endcase
      end
      default: ;
    endcase
  end

  logic signed [33:0] dmv;
  logic signed [34:0] psum;
  logic neg;
  logic [1:0] ax;
  always_comb begin
    // position step target: map local component index to axis
    dmv = 34'((prod + (68'sd1 <<< (MSH - 1))) >>> MSH);
    neg = r_kf ? 1'b0 : (r_kb ? 1'b1 : (r_kr ? 1'b0 : 1'b1));
    // local index 7:a 8:u 9:b -> world axis
    case (mi)
      4'd7: ax = (up_axis == 2'd0) ? 2'd2 : ((up_axis == 2'd2) ? 2'd1 : 2'd0);
      4'd8: ax = (up_axis == 2'd0) ? 2'd0 : ((up_axis == 2'd2) ? 2'd2 : 2'd1);
      default: ax = (up_axis == 2'd0) ? 2'd1 : ((up_axis == 2'd2) ? 2'd0 : 2'd2);
    endcase
    psum = neg ? 35'(pos[ax]) - 35'(dmv) : 35'(pos[ax]) + 35'(dmv);
  end

  function automatic logic signed [15:0] pick(input logic [1:0] axis, input int w,
      input logic signed [33:0] a, input logic signed [33:0] u,
      input logic signed [33:0] b);
    logic signed [33:0] r;
    if (axis == 2'd0) r = (w == 0) ? u : ((w == 1) ? b : a);
    else if (axis == 2'd2) r = (w == 0) ? b : ((w == 1) ? a : u);
    else r = (w == 0) ? a : ((w == 1) ? u : b);
    pick = r[15:0];
  endfunction

  assign in_ready = (state == S_IDLE);
  assign cfg_ready = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign front_x = pick(up_axis, 0, fa, fu, fb);
  assign front_y = pick(up_axis, 1, fa, fu, fb);
  assign front_z = pick(up_axis, 2, fa, fu, fb);
  assign right_x = pick(up_axis, 0, ra, 34'sd0, rb);
  assign right_y = pick(up_axis, 1, ra, 34'sd0, rb);
  assign right_z = pick(up_axis, 2, ra, 34'sd0, rb);
  assign up_x = pick(up_axis, 0, ua, uu, ub);
  assign up_y = pick(up_axis, 1, ua, uu, ub);
  assign up_z = pick(up_axis, 2, ua, uu, ub);
  assign pos_x = pos[0];
  assign pos_y = pos[1];
  assign pos_z = pos[2];

  logic signed [25:0] pnew, yang;
  logic signed [29:0] pwide, ystart, ystep, yred;
  logic signed [25:0] spitch;
  always_comb begin
    pwide = 30'(pitch) + $signed(prod[29:0]);
    if (pwide > 30'(fco_pkg::PITCH_LIM)) pnew = fco_pkg::PITCH_LIM;
    else if (pwide < -30'(fco_pkg::PITCH_LIM)) pnew = -fco_pkg::PITCH_LIM;
    else pnew = pwide[25:0];
    // yaw wrap: lift negatives by sixteen turns, then restoring compare-subtract
    ystart = 30'(yaw) + $signed(prod[29:0]);
    if (ystart < 0) ystart = ystart + (30'(fco_pkg::FULL_TURN) <<< 4);
    ystep = 30'(fco_pkg::FULL_TURN) <<< wk;
    yred = (ywork >= ystep) ? ywork - ystep : ywork;
    spitch = {{2{start_pitch[23]}}, start_pitch};
    if (spitch > fco_pkg::PITCH_LIM) spitch = fco_pkg::PITCH_LIM;
    if (spitch < -fco_pkg::PITCH_LIM) spitch = -fco_pkg::PITCH_LIM;
    if (yaw <= fco_pkg::DEG90) yang = yaw;
    else if (yaw < fco_pkg::DEG270) yang = yaw - fco_pkg::DEG180;
    else yang = yaw - fco_pkg::FULL_TURN;
  end

  logic [25:0] syaw_w;
  assign syaw_w = ({1'b0, start_yaw} >= 26'(fco_pkg::FULL_TURN)) ?
                  {1'b0, start_yaw} - 26'(fco_pkg::FULL_TURN) : {1'b0, start_yaw};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      enable <= 1'b1; up_axis <= 2'd1; base_speed <= 16'd2560;
      sensitivity <= 16'd16384; max_delta <= 12'd10;
      start_pitch <= '0; start_yaw <= '0;
      pitch <= '0; yaw <= '0; last_x <= '0; last_y <= '0;
      pos[0] <= '0; pos[1] <= '0; pos[2] <= '0;
      creq.start <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          fco_pkg::REG_ENABLE: enable <= cfg_data[0];
          fco_pkg::REG_UP_AXIS: up_axis <= cfg_data[1:0];
          fco_pkg::REG_BASE_SPEED: base_speed <= cfg_data[15:0];
          fco_pkg::REG_SENSITIVITY: sensitivity <= cfg_data[15:0];
          fco_pkg::REG_MAX_DELTA: max_delta <= cfg_data[11:0];
          fco_pkg::REG_START_PITCH: start_pitch <= cfg_data[23:0];
          fco_pkg::REG_START_YAW: start_yaw <= cfg_data[24:0];
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: if (in_valid) begin
          r_kf <= key_forward; r_kb <= key_back;
          r_kr <= key_rightward; r_kl <= key_leftward; r_dt <= time_step;
          r_dx <= clampd(17'(cursor_x) - 17'(last_x), max_delta);
          r_dy <= clampd(17'(last_y) - 17'(cursor_y), max_delta);
          tick <= !op && enable;
          mi <= (op || !enable) ? 4'd2 : 4'd0;
          mph <= 1'b0;
          if (op) begin
            pos[0] <= place_x; pos[1] <= place_y; pos[2] <= place_z;
            pitch <= spitch; yaw <= syaw_w;
            last_x <= '0; last_y <= '0;
          end else if (enable) begin
            last_x <= cursor_x; last_y <= cursor_y;
          end
          state <= S_ANG;
        end
        S_ANG: begin
          // angle updates through the shared multiplier
          if (mi == 4'd2) begin
            creq.start <= 1'b1; creq.angle <= pitch; state <= S_CP;
          end else if (!mph) begin
            prod <= ma * mb; mph <= 1'b1;
          end else begin
            mph <= 1'b0;
            if (mi == 4'd0) begin
              pitch <= pnew; mi <= 4'd1;
            end else begin
              ywork <= ystart; wk <= 3'd3; state <= S_WRAP;
            end
          end
        end
        S_WRAP: begin
          if (wk == 3'd0) begin
            yaw <= yred[25:0]; mi <= 4'd2; state <= S_ANG;
          end else begin
            ywork <= yred; wk <= wk - 3'd1;
          end
        end
        S_CP: begin
          creq.start <= 1'b0;
          state <= S_WP;
        end
        S_WP: if (crsp.done) begin
          cp <= crsp.cos_val; sp <= crsp.sin_val;
          creq.start <= 1'b1; creq.angle <= yang;
          flip <= (yaw > fco_pkg::DEG90) && (yaw < fco_pkg::DEG270);
          state <= S_CY;
        end
        S_CY: begin
          creq.start <= 1'b0;
          state <= S_WY;
        end
        S_WY: if (crsp.done) begin
          cyw <= flip ? -crsp.cos_val : crsp.cos_val;
          syw <= flip ? -crsp.sin_val : crsp.sin_val;
          ra <= to_vec(flip ? crsp.sin_val : -crsp.sin_val);
          rb <= to_vec(flip ? -crsp.cos_val : crsp.cos_val);
          fu <= to_vec(sp); uu <= to_vec(cp);
          mph <= 1'b0;
          state <= S_MUL;
        end
        S_MUL: begin
          if (!mph) begin
            prod <= ma * mb; mph <= 1'b1;
          end else begin
            mph <= 1'b0;
            case (mi)
              4'd2: fa <= to_vec(rnd30(prod));
              4'd3: fb <= to_vec(rnd30(prod));
              4'd4: ua <= to_vec(-rnd30(prod));
              4'd5: ub <= to_vec(-rnd30(prod));
              default: travel <= prod[33:0];
            endcase
            mi <= mi + 4'd1;
            if (mi == 4'd5 && !(tick && (r_kf || r_kb || r_kr || r_kl))) state <= S_OUT;
            else if (mi == 4'd6) state <= S_MOVE;
          end
        end
        S_MOVE: begin
          if (!mph) begin
            prod <= ma * mb; mph <= 1'b1;
          end else begin
            mph <= 1'b0;
            if (psum > 35'sd2147483647) pos[ax] <= 32'sh7fffffff;
            else if (psum < -35'sd2147483648) pos[ax] <= 32'sh80000000;
            else pos[ax] <= psum[31:0];
            mi <= mi + 4'd1;
            if (mi == 4'd9) state <= S_OUT;
          end
        end
        S_OUT: if (out_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  `FCO_ASSERT(a_busy_not_ready, clk, rst, (state != S_IDLE) |-> !in_ready, "ready while busy")
  `FCO_ASSERT(a_out_hold, clk, rst, (out_valid && !out_ready) |=> out_valid, "result dropped")
  `FCO_ASSERT(a_pitch_lim, clk, rst, (pitch <= fco_pkg::PITCH_LIM) && (pitch >= -fco_pkg::PITCH_LIM), "pitch out of range")
  `FCO_ASSERT(a_yaw_lim, clk, rst, (yaw >= 0) && (yaw < fco_pkg::FULL_TURN), "yaw out of range")
endmodule

// ----- test/tb.sv -----
// testbench for the camera orientation block: predicts view vectors and position per request
module tb;
  localparam longint GAIN = 64'sd652032874;
  localparam longint DEG = 64'sd65536;
  localparam longint PLIM = 89 * DEG;
  localparam longint TURN = 360 * DEG;
  localparam int STEPS = 16;
  localparam logic [2:0] REG_NONE = 3'd7;

  localparam longint ARCTAN[16] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
    58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115};

  typedef struct {
    longint fr[3];
    longint rt[3];
    longint up[3];
    longint ps[3];
  } view_t;

  logic clk, rst;
  logic in_valid, in_ready, op, key_forward, key_back, key_rightward, key_leftward;
  logic signed [15:0] cursor_x, cursor_y;
  logic [15:0] time_step;
  logic signed [31:0] place_x, place_y, place_z;
  logic out_valid, out_ready;
  logic signed [15:0] front_x, front_y, front_z, right_x, right_y, right_z, up_x, up_y, up_z;
  logic signed [31:0] pos_x, pos_y, pos_z;
  logic cfg_valid, cfg_ready;
  logic [2:0] cfg_index;
  logic [31:0] cfg_data;

  fps_camera_orientation_update_top dut (.*);

  // register shadows and camera state
  longint sh_enable, sh_axis, sh_speed, sh_sens, sh_maxd, sh_pitch0, sh_yaw0;
  longint cam_pitch, cam_yaw, last_cx, last_cy;
  longint cam_pos[3];

  view_t expected_views[$];
  int fails;
  int rx_wait;
  bit calm;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("[fps_camera_orientation_update_top] ERROR");
    $finish;
  end

  function automatic longint clampl(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint wrap360(longint v);
    longint r;
    r = v % TURN;
    return r < 0 ? r + TURN : r;
  endfunction

  function automatic void rotate(input longint ang, output longint c, output longint s);
    longint x, y, z, xs, ys;
    x = GAIN; y = 0; z = ang;
    for (int i = 0; i < STEPS; i++) begin
      xs = x >>> i; ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= ARCTAN[i];
      end else begin
        x += ys; y -= xs; z += ARCTAN[i];
      end
    end
    c = x; s = y;
  endfunction

  function automatic longint q30mul(longint a, longint b);
    return (a * b + (64'sd1 <<< 29)) >>> 30;
  endfunction

  function automatic longint unitq(longint v);
    return clampl((v + (64'sd1 <<< 15)) >>> 16, -16384, 16384);
  endfunction

  function automatic void axes(input longint a, u, b, output longint v[3]);
    if (sh_axis == 0) begin
      v[0] = u; v[1] = b; v[2] = a;
    end else if (sh_axis == 2) begin
      v[0] = b; v[1] = a; v[2] = u;
    end else begin
      v[0] = a; v[1] = u; v[2] = b;
    end
  endfunction

  function automatic view_t predict_view(logic o, kf, kb, kr, kl, longint cx, cy, dt,
                                         longint px, py, pz);
    view_t r;
    longint cp, sp, cw, sw, yang, dx, dy, travel, d, p;
    bit flip, moved, neg;
    flip = 0; moved = 0;
    if (o) begin
      cam_pos[0] = px; cam_pos[1] = py; cam_pos[2] = pz;
      cam_pitch = clampl(sh_pitch0, -PLIM, PLIM);
      cam_yaw = wrap360(sh_yaw0);
      last_cx = 0; last_cy = 0;
    end else if (sh_enable != 0) begin
      dx = clampl(cx - last_cx, -sh_maxd, sh_maxd);
      dy = clampl(last_cy - cy, -sh_maxd, sh_maxd);
      last_cx = cx; last_cy = cy;
      cam_pitch = clampl(cam_pitch + dy * sh_sens, -PLIM, PLIM);
      cam_yaw = wrap360(cam_yaw + dx * sh_sens);
      moved = 1;
    end
    rotate(cam_pitch, cp, sp);
    if (cam_yaw <= 90 * DEG) yang = cam_yaw;
    else if (cam_yaw < 270 * DEG) begin
      yang = cam_yaw - 180 * DEG; flip = 1;
    end else yang = cam_yaw - TURN;
    rotate(yang, cw, sw);
    if (flip) begin
      cw = -cw; sw = -sw;
    end
    axes(unitq(q30mul(cw, cp)), unitq(sp), unitq(q30mul(sw, cp)), r.fr);
    axes(unitq(-sw), 0, unitq(cw), r.rt);
    axes(unitq(-q30mul(cw, sp)), unitq(cp), unitq(-q30mul(sw, sp)), r.up);
    if (moved && (kf || kb || kr || kl)) begin
      travel = sh_speed * dt;
      neg = kf ? 0 : (kb ? 1 : (kr ? 0 : 1));
      for (int k = 0; k < 3; k++) begin
        d = (travel * ((kf || kb) ? r.fr[k] : r.rt[k]) + (64'sd1 <<< 21)) >>> 22;
        p = neg ? cam_pos[k] - d : cam_pos[k] + d;
        cam_pos[k] = clampl(p, -64'sd2147483648, 64'sd2147483647);
      end
    end
    r.ps = cam_pos;
    return r;
  endfunction

  task automatic chk(string name, longint e, longint a);
    if (e != a) begin
      $error("%s: expected %0d, got %0d", name, e, a);
      fails++;
    end
  endtask

  // result side: random stalls, checks every accepted result
  always @(negedge clk) begin
    if (rst) out_ready <= 0;
    else if (rx_wait > 0) begin
      out_ready <= 0;
      rx_wait <= rx_wait - 1;
    end else out_ready <= 1;
  end

  always @(posedge clk) begin
    view_t e;
    if (!rst && out_valid && out_ready) begin
      rx_wait = calm ? 0 : ($urandom_range(0, 3) == 0 ? $urandom_range(0, 14) : 0);
      if (expected_views.size() == 0) begin
        $error("result with no request outstanding");
        fails++;
      end else begin
        e = expected_views.pop_front();
        chk("front_x", e.fr[0], front_x); chk("front_y", e.fr[1], front_y);
        chk("front_z", e.fr[2], front_z);
        chk("right_x", e.rt[0], right_x); chk("right_y", e.rt[1], right_y);
        chk("right_z", e.rt[2], right_z);
        chk("up_x", e.up[0], up_x); chk("up_y", e.up[1], up_y); chk("up_z", e.up[2], up_z);
        chk("pos_x", e.ps[0], pos_x); chk("pos_y", e.ps[1], pos_y);
        chk("pos_z", e.ps[2], pos_z);
      end
    end
  end

  task automatic send_request(logic o, kf, kb, kr, kl, logic [15:0] cx, cy, dt,
                              logic [31:0] px, py, pz);
    int gap;
    gap = calm ? 0 : ($urandom_range(0, 2) == 0 ? $urandom_range(0, 14) : 0);
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    op = o; key_forward = kf; key_back = kb; key_rightward = kr; key_leftward = kl;
    cursor_x = cx; cursor_y = cy; time_step = dt;
    place_x = px; place_y = py; place_z = pz;
    in_valid = 1;
    do @(posedge clk); while (!in_ready);
    expected_views.push_back(predict_view(o, kf, kb, kr, kl, $signed(cx), $signed(cy), dt,
                                          $signed(px), $signed(py), $signed(pz)));
  endtask

  task automatic drain;
    @(negedge clk);
    in_valid = 0;
    while (expected_views.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    @(negedge clk);
    cfg_index = idx; cfg_data = data; cfg_valid = 1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      fco_pkg::REG_ENABLE: sh_enable = data[0];
      fco_pkg::REG_UP_AXIS: sh_axis = data[1:0];
      fco_pkg::REG_BASE_SPEED: sh_speed = data[15:0];
      fco_pkg::REG_SENSITIVITY: sh_sens = data[15:0];
      fco_pkg::REG_MAX_DELTA: sh_maxd = data[11:0];
      fco_pkg::REG_START_PITCH: sh_pitch0 = $signed(data[23:0]);
      fco_pkg::REG_START_YAW: sh_yaw0 = data[24:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 0;
  endtask

  task automatic tick(logic [3:0] keys, logic [15:0] cx, cy, dt);
    send_request(0, keys[3], keys[2], keys[1], keys[0], cx, cy, dt, $urandom, $urandom,
                 $urandom);
  endtask

  task automatic place(logic [31:0] px, py, pz);
    send_request(1, 1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
                 16'($urandom), 16'($urandom), 16'($urandom), px, py, pz);
  endtask

  task automatic test_defaults;
    tick(4'b1000, 16'sd5, -16'sd3, 16'hffff);
    tick(4'b1111, 16'sd32767, -16'sd32768, 16'd1000);
    tick(4'b0111, -16'sd32768, 16'sd32767, 16'd1000);
    tick(4'b0011, 16'sd0, 16'sd0, 16'd30000);
    tick(4'b0001, 16'sd1, 16'sd1, 16'd30000);
    tick(4'b0000, 16'sd2, 16'sd2, 16'd0);
    drain;
  endtask

  task automatic test_extremes;
    write_reg(fco_pkg::REG_START_PITCH, 32'h007f_ffff);
    write_reg(fco_pkg::REG_START_YAW, 32'h01ff_ffff);
    write_reg(fco_pkg::REG_BASE_SPEED, 32'hffff_ffff);
    write_reg(fco_pkg::REG_SENSITIVITY, 32'h0000_ffff);
    write_reg(fco_pkg::REG_MAX_DELTA, 32'h0000_0fff);
    write_reg(REG_NONE, 32'hffff_ffff);
    drain;
    place(32'h7fff_0000, 32'h8000_0000, 32'h7fff_ffff);
    tick(4'b1000, 16'sd100, 16'sd100, 16'hffff);
    tick(4'b0100, -16'sd4000, 16'sd4000, 16'hffff);
    drain;
    write_reg(fco_pkg::REG_START_PITCH, 32'h0080_0000);
    write_reg(fco_pkg::REG_UP_AXIS, 32'd0);
    drain;
    place(32'h8000_0000, 32'h7fff_ffff, 32'h0);
    tick(4'b0010, 16'sd4095, -16'sd4095, 16'hffff);
    drain;
    write_reg(fco_pkg::REG_UP_AXIS, 32'd2);
    write_reg(fco_pkg::REG_MAX_DELTA, 32'd0);
    drain;
    tick(4'b0001, 16'sd300, 16'sd300, 16'd5000);
    drain;
    write_reg(fco_pkg::REG_UP_AXIS, 32'd3);
    write_reg(fco_pkg::REG_ENABLE, 32'd0);
    drain;
    tick(4'b1000, 16'sd7, 16'sd7, 16'hffff);
    place(32'h0001_0000, 32'h0002_0000, 32'hffff_0000);
    tick(4'b0100, 16'sd9, 16'sd9, 16'hffff);
    drain;
    write_reg(fco_pkg::REG_ENABLE, 32'd1);
    write_reg(fco_pkg::REG_UP_AXIS, 32'd1);
    write_reg(fco_pkg::REG_BASE_SPEED, 32'd0);
    drain;
    tick(4'b1000, 16'sd3, 16'sd3, 16'hffff);
    drain;
  endtask

  task automatic random_phase(int n);
    logic [3:0] keys;
    logic [15:0] cx, cy;
    int r;
    write_reg(fco_pkg::REG_ENABLE,
              $urandom_range(0, 5) == 0 ? 32'd0 : 32'd1 | ($urandom & ~32'd1));
    write_reg(fco_pkg::REG_UP_AXIS, $urandom);
    write_reg(fco_pkg::REG_BASE_SPEED,
              $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 4096));
    write_reg(fco_pkg::REG_SENSITIVITY, $urandom);
    write_reg(fco_pkg::REG_MAX_DELTA,
              $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 40));
    write_reg(fco_pkg::REG_START_PITCH, $urandom);
    write_reg(fco_pkg::REG_START_YAW, $urandom);
    drain;
    calm = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      keys = 4'($urandom);
      if (r < 8) place($urandom, $urandom, $urandom);
      else if (r < 20) tick(keys, 16'($urandom), 16'($urandom), 16'($urandom));
      else begin
        cx = 16'(last_cx + $signed($urandom_range(0, 60)) - 30);
        cy = 16'(last_cy + $signed($urandom_range(0, 60)) - 30);
        tick(keys, cx, cy, 16'($urandom_range(0, 3000)));
      end
      if ($urandom_range(0, 60) == 0) begin
        @(negedge clk);
        in_valid = 0;
        while (expected_views.size() != 0) @(posedge clk);
      end
    end
    calm = 0;
    drain;
  endtask

  task automatic test_random;
    for (int p = 0; p < 7; p++) random_phase(120);
  endtask

  initial begin
    rst = 1; in_valid = 0; cfg_valid = 0; cfg_index = fco_pkg::REG_ENABLE; cfg_data = 0;
    op = 0; key_forward = 0; key_back = 0; key_rightward = 0; key_leftward = 0;
    cursor_x = 0; cursor_y = 0; time_step = 0; place_x = 0; place_y = 0; place_z = 0;
    fails = 0; rx_wait = 0; calm = 0;
    sh_enable = 1; sh_axis = 1; sh_speed = 2560; sh_sens = 16384; sh_maxd = 10;
    sh_pitch0 = 0; sh_yaw0 = 0;
    cam_pitch = 0; cam_yaw = 0; last_cx = 0; last_cy = 0;
    cam_pos = '{0, 0, 0};
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 0;
    test_defaults;
    test_extremes;
    test_random;
    drain;
    repeat (60) @(posedge clk);
    if (fails == 0) $display("[fps_camera_orientation_update_top] OK");
    else $display("[fps_camera_orientation_update_top] ERROR");
    $finish;
  end
endmodule
